@@ rtl/core/ntcdt_pkg.sv @@
// Package for the divider-voltage to temperature converter.
// Holds widths, codes, state type and the resistance/temperature table.
// No dependencies.
package ntcdt_pkg;

    localparam int ADC_W      = 16;
    localparam int SUPPLY_W   = 13;
    localparam int RDIV_W     = 20;
    localparam int TEMP_OUT_W = 16;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 20;

    localparam int TABLE_ENTRIES = 39;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int FRAC_BITS     = 4;
    localparam int OHM_W         = 18;
    localparam int OHM_Q_W       = OHM_W + FRAC_BITS;
    localparam int TEMP_W        = 12;
    localparam int DT_W          = TEMP_W + 1;
    localparam int SUM_W         = RDIV_W + 1;

    // shared multiplier and divider widths
    localparam int MUL_A_W = OHM_Q_W + 1;
    localparam int MUL_B_W = ADC_W + 1;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;
    localparam int DIV_N_W = MUL_P_W;
    localparam int DIV_D_W = OHM_Q_W;

    localparam logic [CFG_IDX_W-1:0] CFG_SUPPLY_MV     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DIVIDER_OHM   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NTC_UPPER_LEG = 2'd2;

    localparam logic [SUPPLY_W-1:0] SUPPLY_RST = 13'd3300;
    localparam logic [RDIV_W-1:0]   RDIV_RST   = 20'd10000;

    localparam logic signed [TEMP_OUT_W-1:0] TEMP_SENT_LO = 16'sh8000;
    localparam logic signed [TEMP_OUT_W-1:0] TEMP_SENT_HI = 16'sh7FFF;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK,
        ST_ABOVE,
        ST_BELOW,
        ST_OUTSIDE
    } t_status;

    typedef enum logic [4:0] {
        S_IDLE,
        S_MAXL,
        S_MAXR,
        S_MINL,
        S_MINR,
        S_CHK,
        S_NUM,
        S_DIV1,
        S_RCHK,
        S_SRCH,
        S_INT0,
        S_INT1,
        S_INT2,
        S_NSUB,
        S_DIV2,
        S_FIN,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

    localparam logic [OHM_W-1:0] LUT_OHM [TABLE_ENTRIES] = '{
        18'd188500, 18'd144300, 18'd111300, 18'd86560, 18'd67790, 18'd53460,
        18'd42450, 18'd33930, 18'd27280, 18'd22070, 18'd17960, 18'd14700,
        18'd12090, 18'd10000, 18'd8312, 18'd6942, 18'd5826, 18'd4911,
        18'd4158, 18'd3536, 18'd3019, 18'd2588, 18'd2227, 18'd1924,
        18'd1668, 18'd1451, 18'd1267, 18'd1110, 18'd975, 18'd860,
        18'd760, 18'd674, 18'd599, 18'd534, 18'd478, 18'd428,
        18'd385, 18'd346, 18'd313
    };

    localparam logic signed [TEMP_W-1:0] LUT_TEMP [TABLE_ENTRIES] = '{
        -12'sd400, -12'sd350, -12'sd300, -12'sd250, -12'sd200, -12'sd150,
        -12'sd100, -12'sd50, 12'sd0, 12'sd50, 12'sd100, 12'sd150,
        12'sd200, 12'sd250, 12'sd300, 12'sd350, 12'sd400, 12'sd450,
        12'sd500, 12'sd550, 12'sd600, 12'sd650, 12'sd700, 12'sd750,
        12'sd800, 12'sd850, 12'sd900, 12'sd950, 12'sd1000, 12'sd1050,
        12'sd1100, 12'sd1150, 12'sd1200, 12'sd1250, 12'sd1300, 12'sd1350,
        12'sd1400, 12'sd1450, 12'sd1500
    };

    localparam logic [OHM_W-1:0] OHM_HI = LUT_OHM[0];
    localparam logic [OHM_W-1:0] OHM_LO = LUT_OHM[TABLE_ENTRIES-1];

    // table resistance in Q.4 ohms
    function automatic logic [OHM_Q_W-1:0] ohm_q(input logic [IDX_W-1:0] idx);
        return {LUT_OHM[idx], {FRAC_BITS{1'b0}}};
    endfunction

endpackage

@@ rtl/core/ntcdt_cfg_if.sv @@
// Register write channel of the converter.
// Depends on ntcdt_pkg.
interface ntcdt_cfg_if
    import ntcdt_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output idx, output data, input ready);
    modport sink   (input valid, input idx, input data, output ready);
endinterface

@@ rtl/core/ntcdt_in_if.sv @@
// Input channel: one divider voltage per transaction.
// Depends on ntcdt_pkg.
interface ntcdt_in_if
    import ntcdt_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [ADC_W-1:0] adc_mv;

    modport source (output valid, output adc_mv, input ready);
    modport sink   (input valid, input adc_mv, output ready);
endinterface

@@ rtl/core/ntcdt_out_if.sv @@
// Result channel: temperature and status per transaction.
// Depends on ntcdt_pkg.
interface ntcdt_out_if
    import ntcdt_pkg::*;
();
    logic                         valid;
    logic                         ready;
    logic signed [TEMP_OUT_W-1:0] temp_ddegc;
    logic [STATUS_W-1:0]          status;

    modport source (output valid, output temp_ddegc, output status, input ready);
    modport sink   (input valid, input temp_ddegc, input status, output ready);
endinterface

@@ rtl/core/ntc_divider_temperature_lut_top.sv @@
// Top level of the divider-voltage to temperature converter.
// Depends on ntcdt_pkg, the three channel interfaces and ntcdt_div.
//
// Converts one divider voltage (mV) to a temperature in 0.1 degC. The voltage
// is first checked against the divider voltages at both table ends; outside
// that window the result is a sentinel with status 1 or status 2, and a
// degenerate voltage or a solved resistance outside the table gives 0 with
// status 3. In range, the thermistor resistance is solved in Q.4 ohms, the
// descending table is walked one entry per cycle, and the bracketing pair is
// interpolated with truncation toward zero. Two divisions on the shared
// one-bit-per-cycle restoring divider and the table walk dominate the time of
// a transaction, and a single 23x17 multiplier serves all products. Input is
// accepted only in the idle state; a finished result waits in the output
// register. The user must write the registers only while the block is idle;
// the block itself does not enforce this.
module ntc_divider_temperature_lut_top
    import ntcdt_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    ntcdt_cfg_if.sink    i_cfg,
    ntcdt_in_if.sink     i_adc,
    ntcdt_out_if.source  o_res
);

    t_state r_state, n_state;

    logic [SUPPLY_W-1:0] r_supply;
    logic [RDIV_W-1:0]   r_rdiv;
    logic                r_upper;

    logic [ADC_W-1:0]           r_adc;
    logic signed [MUL_P_W-1:0]  r_pa;
    logic signed [MUL_P_W-1:0]  r_pb;
    logic [OHM_Q_W-1:0]         r_r;
    logic [OHM_Q_W-1:0]         r_d;
    logic [OHM_Q_W-1:0]         r_rx;
    logic [IDX_W-1:0]           r_k;
    logic                       r_neg;
    logic signed [TEMP_OUT_W-1:0] r_stg_temp;
    t_status                    r_stg_st;

    logic                         r_out_valid;
    logic signed [TEMP_OUT_W-1:0] r_out_temp;
    t_status                      r_out_st;

    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [MUL_P_W-1:0] mul_p;

    logic               div_start;
    logic [DIV_N_W-1:0] div_dividend;
    logic [DIV_D_W-1:0] div_divisor;
    logic [DIV_N_W-1:0] div_quot;
    t_div_stat          div_stat;

    logic                       in_acc;
    logic                       out_load;
    logic [SUM_W-1:0]           sum_hi;
    logic [SUM_W-1:0]           sum_lo;
    logic [SUPPLY_W-1:0]        s_minus_adc;
    logic                       degen;
    logic                       max_fail;
    logic                       min_fail;
    logic                       r_bad;
    logic                       srch_go;
    logic [IDX_W-1:0]           kp1;
    logic [OHM_Q_W-1:0]         x1;
    logic [OHM_Q_W-1:0]         x2;
    logic signed [TEMP_W-1:0]   y0;
    logic signed [TEMP_W-1:0]   y1;
    logic signed [DT_W-1:0]     dt;
    logic signed [MUL_P_W-1:0]  n_val;
    logic [TEMP_OUT_W-1:0]      q_lo;

    assign in_acc   = i_adc.valid && i_adc.ready;
    assign out_load = (r_state == S_EMIT) && (!r_out_valid || o_res.ready);

    assign sum_hi      = SUM_W'(OHM_HI) + SUM_W'(r_rdiv);
    assign sum_lo      = SUM_W'(OHM_LO) + SUM_W'(r_rdiv);
    assign s_minus_adc = r_supply - r_adc[SUPPLY_W-1:0];
    assign degen       = r_upper ? ((r_adc == '0) || (r_adc > ADC_W'(r_supply)))
                                 : (r_adc >= ADC_W'(r_supply));
    assign max_fail    = r_pa > r_pb;
    assign min_fail    = r_pa < r_pb;
    assign r_bad       = (div_quot > DIV_N_W'(ohm_q(IDX_W'(0))))
                      || (div_quot < DIV_N_W'(ohm_q(IDX_W'(TABLE_ENTRIES - 1))));

    assign kp1     = r_k + 1'b1;
    assign x1      = ohm_q(kp1);
    assign x2      = ohm_q(r_k);
    assign y0      = LUT_TEMP[r_k];
    assign y1      = LUT_TEMP[kp1];
    assign dt      = DT_W'(y1) - DT_W'(y0);
    assign srch_go = (r_k < IDX_W'(TABLE_ENTRIES - 2)) && (r_r < x1);
    assign n_val   = r_pa - r_pb;
    assign q_lo    = div_quot[TEMP_OUT_W-1:0];

    assign mul_p = mul_a * mul_b;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (in_acc) n_state = S_MAXL;
            S_MAXL: n_state = S_MAXR;
            S_MAXR: n_state = S_MINL;
            S_MINL: n_state = max_fail ? S_EMIT : S_MINR;
            S_MINR: n_state = S_CHK;
            S_CHK:  n_state = (min_fail || degen) ? S_EMIT : S_NUM;
            S_NUM:  n_state = S_DIV1;
            S_DIV1: if (div_stat.done) n_state = S_RCHK;
            S_RCHK: n_state = r_bad ? S_EMIT : S_SRCH;
            S_SRCH: if (!srch_go) n_state = S_INT0;
            S_INT0: n_state = (x2 <= x1) ? S_EMIT : S_INT1;
            S_INT1: n_state = S_INT2;
            S_INT2: n_state = S_NSUB;
            S_NSUB: n_state = S_DIV2;
            S_DIV2: if (div_stat.done) n_state = S_FIN;
            S_FIN:  n_state = S_EMIT;
            S_EMIT: if (out_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // unit controls and operand selection
    always_comb begin
        mul_a        = '0;
        mul_b        = '0;
        div_start    = 1'b0;
        div_dividend = {mul_p[DIV_N_W-FRAC_BITS-1:0], {FRAC_BITS{1'b0}}};
        div_divisor  = DIV_D_W'(r_upper ? r_adc[SUPPLY_W-1:0] : s_minus_adc);
        case (r_state)
            S_MAXL: begin
                mul_a = MUL_A_W'(r_upper ? sum_lo : sum_hi);
                mul_b = MUL_B_W'(r_adc);
            end
            S_MAXR: begin
                mul_a = MUL_A_W'(r_upper ? OHM_Q_W'(r_rdiv) : OHM_Q_W'(OHM_HI));
                mul_b = MUL_B_W'(r_supply);
            end
            S_MINL: begin
                mul_a = MUL_A_W'(r_upper ? sum_hi : sum_lo);
                mul_b = MUL_B_W'(r_adc);
            end
            S_MINR: begin
                mul_a = MUL_A_W'(r_upper ? OHM_Q_W'(r_rdiv) : OHM_Q_W'(OHM_LO));
                mul_b = MUL_B_W'(r_supply);
            end
            S_NUM: begin
                mul_a     = MUL_A_W'(r_rdiv);
                mul_b     = r_upper ? MUL_B_W'(s_minus_adc) : MUL_B_W'(r_adc);
                div_start = 1'b1;
            end
            S_INT1: begin
                mul_a = MUL_A_W'(r_d);
                mul_b = MUL_B_W'(y1);
            end
            S_INT2: begin
                mul_a = MUL_A_W'(r_rx);
                mul_b = MUL_B_W'(dt);
            end
            S_NSUB: begin
                div_start    = 1'b1;
                div_dividend = n_val[MUL_P_W-1] ? DIV_N_W'(-n_val) : DIV_N_W'(n_val);
                div_divisor  = r_d;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_supply    <= SUPPLY_RST;
            r_rdiv      <= RDIV_RST;
            r_upper     <= 1'b0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg.valid) begin
                case (i_cfg.idx)
                    CFG_SUPPLY_MV:     r_supply <= i_cfg.data[SUPPLY_W-1:0];
                    CFG_DIVIDER_OHM:   r_rdiv   <= i_cfg.data[RDIV_W-1:0];
                    CFG_NTC_UPPER_LEG: r_upper  <= i_cfg.data[0];
                    default: ;
                endcase
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: if (in_acc) r_adc <= i_adc.adc_mv;
            S_MAXL: r_pa <= mul_p;
            S_MAXR: r_pb <= mul_p;
            S_MINL: begin
                r_pa       <= mul_p;
                r_stg_temp <= TEMP_SENT_LO;
                r_stg_st   <= ST_ABOVE;
            end
            S_MINR: r_pb <= mul_p;
            S_CHK: begin
                if (min_fail) begin
                    r_stg_temp <= TEMP_SENT_HI;
                    r_stg_st   <= ST_BELOW;
                end else begin
                    r_stg_temp <= '0;
                    r_stg_st   <= ST_OUTSIDE;
                end
            end
            S_RCHK: begin
                r_r        <= div_quot[OHM_Q_W-1:0];
                r_k        <= '0;
                r_stg_temp <= '0;
                r_stg_st   <= ST_OUTSIDE;
            end
            S_SRCH: if (srch_go) r_k <= kp1;
            S_INT0: begin
                r_d        <= x2 - x1;
                r_rx       <= r_r - x1;
                r_stg_temp <= TEMP_OUT_W'(y1);
                r_stg_st   <= ST_OK;
            end
            S_INT1: r_pa <= mul_p;
            S_INT2: r_pb <= mul_p;
            S_NSUB: r_neg <= n_val[MUL_P_W-1];
            S_FIN: begin
                r_stg_temp <= r_neg ? (TEMP_OUT_W'(0) - q_lo) : q_lo;
                r_stg_st   <= ST_OK;
            end
            default: ;
        endcase
        if (out_load) begin
            r_out_temp <= r_stg_temp;
            r_out_st   <= r_stg_st;
        end
    end

    ntcdt_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_quot     (div_quot),
        .o_stat     (div_stat)
    );

    assign i_cfg.ready = 1'b1;
    assign i_adc.ready = (r_state == S_IDLE);

    assign o_res.valid      = r_out_valid;
    assign o_res.temp_ddegc = r_out_temp;
    assign o_res.status     = r_out_st;

`ifndef SYNTH
    a_start_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state == S_MAXL))
        else $error("accepted transaction did not start the range check");

    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> !div_stat.busy)
        else $error("divider restarted while busy");

    a_srch_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SRCH) |-> (r_k <= IDX_W'(TABLE_ENTRIES - 2)))
        else $error("table walk ran past the last interval");

    a_wait_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV2) && !div_stat.done |-> div_stat.busy)
        else $error("waiting for a divider that is not running");
`endif

endmodule

@@ rtl/core/ntcdt_div.sv @@
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on ntcdt_pkg.
module ntcdt_div
    import ntcdt_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [DIV_N_W-1:0] i_dividend,
    input  logic [DIV_D_W-1:0] i_divisor,
    output logic [DIV_N_W-1:0] o_quot,
    output t_div_stat          o_stat
);

    localparam int CNT_W = $clog2(DIV_N_W + 1);

    logic [CNT_W-1:0]   r_cnt;
    logic               r_busy;
    logic               r_done;
    logic [DIV_N_W-1:0] r_q;
    logic [DIV_D_W-1:0] r_rem;
    logic [DIV_D_W-1:0] r_dsr;
    logic [DIV_D_W:0]   rem_sh;
    logic               fits;

    assign rem_sh = {r_rem, r_q[DIV_N_W-1]};
    assign fits   = rem_sh >= {1'b0, r_dsr};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= !i_start && r_busy && (r_cnt == CNT_W'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DIV_N_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_dsr <= i_divisor;
        end else if (r_busy) begin
            // shift in the next dividend bit, subtract when it fits
            if (fits) begin
                r_rem <= DIV_D_W'(rem_sh - {1'b0, r_dsr});
            end else begin
                r_rem <= rem_sh[DIV_D_W-1:0];
            end
            r_q <= {r_q[DIV_N_W-2:0], fits};
        end
    end

    assign o_quot      = r_q;
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

endmodule
